[src/assert_macros.svh]
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define XSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xss check failed");

// Antecedent implies consequent in the next cycle.
`define XSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xss check failed");

`endif

[src/xss_pkg.sv]
// Shared types, constants and substitution table for the block cipher.
package xss_pkg;

  localparam int MAX_BLOCK_DEFAULT = 8;
  localparam int CFG_IDX_W = 2;
  localparam int KEY_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY       = 2'd1;

  localparam logic [3:0] BLOCK_LEN_RST = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_END
  } xss_state_e;

  // Common control for the row of buffer cells.
  typedef struct packed {
    logic       shift;
    logic       load;
    logic [7:0] data;
  } cell_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'd47, 8'd164, 8'd147, 8'd166, 8'd221, 8'd246, 8'd1, 8'd13,
    8'd198, 8'd78, 8'd102, 8'd219, 8'd75, 8'd97, 8'd62, 8'd140,
    8'd84, 8'd69, 8'd107, 8'd99, 8'd185, 8'd220, 8'd179, 8'd61,
    8'd187, 8'd0, 8'd92, 8'd112, 8'd8, 8'd33, 8'd15, 8'd119,
    8'd209, 8'd178, 8'd192, 8'd12, 8'd121, 8'd239, 8'd117, 8'd96,
    8'd100, 8'd126, 8'd118, 8'd199, 8'd208, 8'd50, 8'd42, 8'd168,
    8'd14, 8'd171, 8'd17, 8'd238, 8'd158, 8'd207, 8'd144, 8'd58,
    8'd127, 8'd182, 8'd146, 8'd71, 8'd68, 8'd157, 8'd154, 8'd88,
    8'd248, 8'd105, 8'd131, 8'd235, 8'd98, 8'd170, 8'd22, 8'd160,
    8'd181, 8'd4, 8'd254, 8'd70, 8'd202, 8'd225, 8'd67, 8'd205,
    8'd216, 8'd25, 8'd43, 8'd222, 8'd236, 8'd128, 8'd122, 8'd77,
    8'd59, 8'd145, 8'd167, 8'd54, 8'd20, 8'd55, 8'd152, 8'd149,
    8'd230, 8'd211, 8'd224, 8'd111, 8'd165, 8'd124, 8'd16, 8'd243,
    8'd213, 8'd114, 8'd116, 8'd63, 8'd64, 8'd176, 8'd31, 8'd161,
    8'd9, 8'd229, 8'd95, 8'd247, 8'd193, 8'd18, 8'd134, 8'd79,
    8'd133, 8'd173, 8'd82, 8'd51, 8'd57, 8'd136, 8'd6, 8'd49,
    8'd5, 8'd197, 8'd115, 8'd65, 8'd169, 8'd255, 8'd249, 8'd195,
    8'd30, 8'd162, 8'd150, 8'd53, 8'd83, 8'd46, 8'd228, 8'd81,
    8'd237, 8'd104, 8'd28, 8'd223, 8'd217, 8'd251, 8'd200, 8'd60,
    8'd132, 8'd194, 8'd151, 8'd137, 8'd191, 8'd74, 8'd201, 8'd103,
    8'd29, 8'd80, 8'd113, 8'd101, 8'd250, 8'd172, 8'd234, 8'd180,
    8'd73, 8'd141, 8'd204, 8'd27, 8'd241, 8'd188, 8'd153, 8'd155,
    8'd86, 8'd94, 8'd177, 8'd87, 8'd39, 8'd91, 8'd2, 8'd48,
    8'd35, 8'd40, 8'd120, 8'd159, 8'd184, 8'd123, 8'd215, 8'd138,
    8'd210, 8'd108, 8'd76, 8'd106, 8'd36, 8'd189, 8'd125, 8'd226,
    8'd252, 8'd37, 8'd66, 8'd156, 8'd253, 8'd218, 8'd85, 8'd203,
    8'd110, 8'd10, 8'd244, 8'd45, 8'd34, 8'd242, 8'd72, 8'd93,
    8'd52, 8'd135, 8'd44, 8'd245, 8'd3, 8'd32, 8'd196, 8'd163,
    8'd232, 8'd240, 8'd227, 8'd24, 8'd139, 8'd183, 8'd38, 8'd233,
    8'd130, 8'd143, 8'd109, 8'd41, 8'd174, 8'd231, 8'd129, 8'd23,
    8'd148, 8'd89, 8'd212, 8'd19, 8'd21, 8'd142, 8'd7, 8'd214,
    8'd56, 8'd90, 8'd11, 8'd190, 8'd175, 8'd206, 8'd26, 8'd186
  };

  function automatic logic [7:0] sbox_lookup(input logic [7:0] x);
    return SBOX[x];
  endfunction

endpackage

[src/xss_cell.sv]
// One byte cell of the block buffer: loads a key-mixed byte or takes its neighbor's byte.
module xss_cell
  import xss_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctl_t  ctl_i,
  input  logic       sel_i,
  input  logic [7:0] shift_in_i,
  output logic [7:0] q_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load && sel_i) begin
      byte_q <= ctl_i.data;
    end else if (ctl_i.shift) begin
      byte_q <= shift_in_i;
    end
  end

  assign q_o = byte_q;

endmodule

[src/xss_ctrl.sv]
// Sequencer: config registers, fill and flush counters, output register with S-box.
module xss_ctrl
  import xss_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEFAULT,
  localparam int CNT_W = $clog2(MAX_BLOCK + 1),
  localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [KEY_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           plain_byte_i,
  input  logic                 end_of_stream_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           cipher_byte_o,
  output logic                 end_marker_o,
  output logic                 last_of_run_o,
  input  logic [7:0]           head_i,
  output cell_ctl_t            cell_ctl_o,
  output logic [IDX_W-1:0]     load_idx_o
);

  xss_state_e       state_q, state_d;
  logic [3:0]       block_len_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       pend_byte_q;
  logic             pend_eos_q;
  logic             pend_save;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_end_q, out_last_q;
  logic             out_load;
  logic [7:0]       out_byte_d;
  logic             out_end_d, out_last_d;

  logic [CNT_W-1:0] len_eff, half, wr_pos, wr_slot;
  logic [2:0]       key_sel;
  logic [7:0]       key_byte, wr_byte;
  logic             can_load, in_acc, full, last_cnt;

  always_comb begin
    len_eff = CNT_W'(block_len_q);
    if (block_len_q == 4'd0) begin
      len_eff = CNT_W'(1);
    end else if (int'(block_len_q) > MAX_BLOCK) begin
      len_eff = CNT_W'(MAX_BLOCK);
    end
  end

  assign half     = len_eff >> 1;
  assign full     = (fill_q >= len_eff);
  assign last_cnt = (cnt_q == len_eff - CNT_W'(1));

  // A byte is stored at its emit slot, so a plain shift yields the swapped order.
  assign wr_pos = (state_q == ST_FLUSH) ? '0 : fill_q;
  always_comb begin
    if (wr_pos < half) begin
      wr_slot = wr_pos + half;
    end else if (wr_pos < (half << 1)) begin
      wr_slot = wr_pos - half;
    end else begin
      wr_slot = wr_pos;
    end
  end

  assign key_sel    = 3'(wr_pos);
  assign key_byte   = key_q[{key_sel, 3'b000} +: 8];
  assign wr_byte    = (state_q == ST_FLUSH) ? pend_byte_q : plain_byte_i;
  assign load_idx_o = IDX_W'(wr_slot);

  assign can_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && can_load);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d          = state_q;
    fill_d           = fill_q;
    cnt_d            = cnt_q;
    pend_save        = 1'b0;
    out_load         = 1'b0;
    out_byte_d       = 8'h00;
    out_end_d        = 1'b0;
    out_last_d       = 1'b0;
    cell_ctl_o.shift = 1'b0;
    cell_ctl_o.load  = 1'b0;
    cell_ctl_o.data  = wr_byte ^ key_byte;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (full) begin
            pend_save = 1'b1;
            cnt_d     = '0;
            state_d   = ST_FLUSH;
          end else if (end_of_stream_i) begin
            out_load   = 1'b1;
            out_end_d  = 1'b1;
            out_last_d = 1'b1;
            fill_d     = '0;
          end else begin
            cell_ctl_o.load = 1'b1;
            fill_d          = fill_q + CNT_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (can_load) begin
          out_load         = 1'b1;
          out_byte_d       = sbox_lookup(head_i);
          out_last_d       = last_cnt && !pend_eos_q;
          cell_ctl_o.shift = 1'b1;
          cnt_d            = cnt_q + CNT_W'(1);
          if (last_cnt) begin
            if (pend_eos_q) begin
              fill_d  = '0;
              state_d = ST_END;
            end else begin
              // the held byte opens the next block
              cell_ctl_o.load = 1'b1;
              fill_d          = CNT_W'(1);
              state_d         = ST_IDLE;
            end
          end
        end
      end
      ST_END: begin
        if (can_load) begin
          out_load   = 1'b1;
          out_end_d  = 1'b1;
          out_last_d = 1'b1;
          fill_d     = '0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // a block length write drops the pending block
    if (cfg_we_i && (cfg_idx_i == REG_BLOCK_LEN)) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      block_len_q <= BLOCK_LEN_RST;
      key_q       <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BLOCK_LEN: begin
            block_len_q <= cfg_data_i[3:0];
          end
          REG_KEY: begin
            key_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_save) begin
      pend_byte_q <= plain_byte_i;
      pend_eos_q  <= end_of_stream_i;
    end
    if (out_load) begin
      out_byte_q <= out_byte_d;
      out_end_q  <= out_end_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = out_byte_q;
  assign end_marker_o  = out_end_q;
  assign last_of_run_o = out_last_q;

endmodule

[src/xor_swap_sbox_block_cipher.sv]
// Top level: key-XOR, half-swap, S-box byte block cipher built on a row of byte cells.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o   | plain_byte_i, end_of_stream_i
//   out     | output    | out_valid_o / out_stall_i | cipher_byte_o, end_marker_o, last_of_run_o
//   cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// A byte that arrives while the block is not yet full is stored directly in its cell.
// A word arriving on a full block is held while the len bytes shift through the
// cell row, one result per cycle while out is not stalled; an end word then adds the end result.
// Reset clears the fill count and loads block_len 8 and a zero key; no clearing pass.
// Out stalls freeze the cell row and the sequencer; input is stalled during a flush.
module xor_swap_sbox_block_cipher
  import xss_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [KEY_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           plain_byte_i,
  input  logic                 end_of_stream_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           cipher_byte_o,
  output logic                 end_marker_o,
  output logic                 last_of_run_o
);

  localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  cell_ctl_t        cell_ctl;
  logic [IDX_W-1:0] load_idx;
  logic [7:0]       cell_q [MAX_BLOCK];

  xss_ctrl #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .plain_byte_i   (plain_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cipher_byte_o  (cipher_byte_o),
    .end_marker_o   (end_marker_o),
    .last_of_run_o  (last_of_run_o),
    .head_i         (cell_q[0]),
    .cell_ctl_o     (cell_ctl),
    .load_idx_o     (load_idx)
  );

  // Cell k hands its byte to cell k-1 on each flush shift; cell 0 feeds the S-box.
  for (genvar k = 0; k < MAX_BLOCK; k++) begin : g_cell
    logic [7:0] shift_in;
    if (k == MAX_BLOCK - 1) begin : g_tail
      assign shift_in = 8'h00;
    end else begin : g_body
      assign shift_in = cell_q[k+1];
    end
    xss_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (cell_ctl),
      .sel_i     (load_idx == IDX_W'(k)),
      .shift_in_i(shift_in),
      .q_o       (cell_q[k])
    );
  end

endmodule

[src/xss_checker.sv]
// Port-level checker for the block cipher, bound to the top level.
`include "assert_macros.svh"

module xss_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] cipher_byte_o,
  input logic       end_marker_o,
  input logic       last_of_run_o
);

  // A stalled word holds.
  `XSS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(cipher_byte_o) && $stable(end_marker_o) && $stable(last_of_run_o))

  // The end result carries a zero byte and closes its run.
  `XSS_ASSERT_IMP(a_end_form, clk_i, rst_ni, out_valid_o && end_marker_o, cipher_byte_o == 8'h00 && last_of_run_o)

  // Inside a run the next result follows without a gap.
  `XSS_ASSERT_NXT(a_run_gapless, clk_i, rst_ni, out_valid_o && !last_of_run_o, out_valid_o)

  // No new word is taken while a run is still being emitted.
  `XSS_ASSERT_IMP(a_run_blocks_in, clk_i, rst_ni, out_valid_o && !last_of_run_o, in_stall_o)

endmodule

bind xor_swap_sbox_block_cipher xss_port_checker u_xss_checker (.*);

[verif/xss_checker.sv]
// Checker for the block cipher: tracks config, predicts output words and compares them.
`timescale 1ns / 1ps

module xss_checker
  import xss_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [KEY_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [7:0]           plain_byte_i,
  input  logic                 end_of_stream_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [7:0]           cipher_byte_i,
  input  logic                 end_marker_i,
  input  logic                 last_of_run_i,
  output int                   errors_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [7:0] cipher;
    logic       end_m;
    logic       last;
  } cipher_word_t;

  cipher_word_t cipher_q[$];

  // predicted state
  logic [7:0]     blk_bytes [MAX_BLOCK];
  int unsigned    fill;
  logic [3:0]     blk_len;
  logic [KEY_W-1:0] key;

  int mismatches;
  assign errors_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Push the words one accepted input word causes and advance the block state.
  task automatic cipher_step(input logic [7:0] pb, input logic eos);
    int unsigned  len;
    int unsigned  half;
    int unsigned  src;
    int           pushed;
    cipher_word_t w;
    pushed = 0;
    len = (blk_len == 0) ? 1 : ((blk_len > MAX_BLOCK) ? MAX_BLOCK : blk_len);
    if (fill >= len) begin
      half = len / 2;
      for (int i = 0; i < len; i++) begin
        if (i < half) src = i + half;
        else if (i < 2 * half) src = i - half;
        else src = i;
        w.cipher = SBOX[blk_bytes[src % MAX_BLOCK]];
        w.end_m  = 1'b0;
        w.last   = 1'b0;
        cipher_q.push_back(w);
        pushed++;
      end
      fill = 0;
    end
    if (eos) begin
      w.cipher = 8'd0;
      w.end_m  = 1'b1;
      w.last   = 1'b0;
      cipher_q.push_back(w);
      pushed++;
      fill = 0;
    end else begin
      blk_bytes[fill % MAX_BLOCK] = pb ^ key[(fill % 8) * 8 +: 8];
      fill++;
    end
    if (pushed > 0) cipher_q[cipher_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_word_t w;
    if (!rst_ni) begin
      cipher_q.delete();
      fill      = 0;
      blk_len   = BLOCK_LEN_RST;
      key       = '0;
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BLOCK_LEN: begin
            blk_len = cfg_data_i[3:0];
            fill    = 0;
          end
          REG_KEY: key = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) cipher_step(plain_byte_i, end_of_stream_i);
      if (out_valid_i && !out_stall_i) begin
        if (cipher_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word byte=%0d end=%0b last=%0b",
                                    cipher_byte_i, end_marker_i, last_of_run_i));
        end else begin
          w = cipher_q.pop_front();
          if (cipher_byte_i !== w.cipher)
            report_mismatch($sformatf("cipher_byte %0d, expected %0d", cipher_byte_i, w.cipher));
          if (end_marker_i !== w.end_m)
            report_mismatch($sformatf("end_marker %0b, expected %0b", end_marker_i, w.end_m));
          if (last_of_run_i !== w.last)
            report_mismatch($sformatf("last_of_run %0b, expected %0b", last_of_run_i, w.last));
        end
      end
      pending_o <= cipher_q.size();
    end
  end

endmodule

[verif/testbench.sv]
// Top of the block cipher regression: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import xss_pkg::*;

  localparam int BLK_MAX       = MAX_BLOCK_DEFAULT;
  localparam int SETTLE_CYCLES = BLK_MAX + 4;
  localparam int RAND_ITEMS    = 380;
  localparam int QUIET_LIMIT   = 2000;

  // indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [3:0] LEN_SWEEP [11] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd7,
                                            4'd2, 4'd9, 4'd5, 4'd3, 4'd6};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [KEY_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           plain_byte_i;
  logic                 end_of_stream_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [7:0]           cipher_byte_o;
  logic                 end_marker_o;
  logic                 last_of_run_o;

  int errors;
  int exp_pending;
  int rand_items;
  int quiet;
  bit calm;

  xor_swap_sbox_block_cipher dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .plain_byte_i    (plain_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cipher_byte_o   (cipher_byte_o),
    .end_marker_o    (end_marker_o),
    .last_of_run_o   (last_of_run_o)
  );

  xss_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .plain_byte_i    (plain_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cipher_byte_i   (cipher_byte_o),
    .end_marker_i    (end_marker_o),
    .last_of_run_i   (last_of_run_o),
    .errors_o        (errors),
    .pending_o       (exp_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 31);
  end

  // Ends a hung run: counts cycles with no word moved and no register write.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("xor_swap_sbox_block_cipher regression: fail");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Called and returns at a falling edge; valid stays high for back-to-back words unless a random gap drops it.
  task automatic send_word(input logic [7:0] pb, input logic eos);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    plain_byte_i    <= pb;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
    in_valid_i <= 1'b0;
    while (exp_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_bytes(input int n);
    for (int k = 0; k < n; k++) send_word(8'($urandom), 1'b0);
  endtask

  initial begin
    logic [3:0]       blen;
    logic [KEY_W-1:0] data;
    int               elen;
    int               quota;
    int               phase;
    int               r;
    int               nbytes;
    bit               close;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_BLOCK_LEN;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    plain_byte_i    = 8'd0;
    end_of_stream_i = 1'b0;
    out_stall_i     = 1'b0;
    quiet           = 0;
    rand_items      = 0;
    calm            = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: 8-byte blocks, zero key; full block then end flushes 9 words
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'hFE, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);       // end on empty block
    send_random_bytes(3);
    send_word(8'hA5, 1'b1);       // partial block dropped

    write_reg(REG_KEY, '1);
    write_reg(REG_BLOCK_LEN, 64'd3);   // odd length: last byte stays put
    send_random_bytes(3);
    send_word(8'h3C, 1'b0);       // byte on full block: flush without end
    send_random_bytes(2);
    send_word(8'h00, 1'b1);
    send_random_bytes(2);         // pending bytes discarded by the length write
    write_reg(REG_BLOCK_LEN, 64'd0);   // zero acts as one
    send_word(8'hC3, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'h00, 1'b1);

    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      blen = (phase < $size(LEN_SWEEP)) ? LEN_SWEEP[phase] : 4'($urandom_range(0, 15));
      data = {$urandom, $urandom};
      write_reg(REG_BLOCK_LEN, {data[KEY_W-1:4], blen});
      case (phase % 3)
        0:       data = '0;
        1:       data = '1;
        default: data = {$urandom, $urandom};
      endcase
      write_reg(REG_KEY, data);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
      elen  = (blen == 0) ? 1 : ((blen > BLK_MAX) ? BLK_MAX : blen);
      quota = rand_items + $urandom_range(25, 45);
      while (rand_items < quota) begin
        calm = (rand_items >= 150 && rand_items < 240);
        r = $urandom_range(0, 99);
        if (r < 70) begin
          nbytes = elen;
          close  = ($urandom_range(0, 2) == 0);
        end else if (r < 85) begin
          nbytes = 0;
          close  = 1'b1;
        end else begin
          nbytes = $urandom_range(0, elen - 1);
          close  = 1'b1;
        end
        send_random_bytes(nbytes);
        rand_items += nbytes;
        if (close) begin
          send_word(8'($urandom), 1'b1);
          rand_items++;
        end
      end
      phase++;
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (exp_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (errors == 0 && exp_pending == 0) begin
      $display("xor_swap_sbox_block_cipher regression: pass");
    end else begin
      $display("xor_swap_sbox_block_cipher regression: fail");
    end
    $finish;
  end

endmodule
